// File: rtl/core/lpe_pkg.sv
// Shared types, constants and the color-count lookup for the LSB payload pixel embedder.
`timescale 1ns / 1ps
`default_nettype none

package lpe_pkg;

   // Field widths fixed by the interface
   localparam int unsigned BYTE_W = 8;
   localparam int unsigned CODE_W = 8;
   localparam int unsigned HELD_W = 5;
   localparam int unsigned BITS_W = 6;   // widest pop: 2 bits per channel times 3 channels
   localparam int unsigned BPP_W  = 3;
   localparam int unsigned LEN_W  = 4;

   // Input item kinds
   localparam logic MODE_BYTE  = 1'b0;
   localparam logic MODE_PIXEL = 1'b1;

   // Reset value of the color count register
   localparam logic [BYTE_W-1:0] NUM_COLORS_RESET = 8'd31;

   // Level table: color count bound, bits per pixel (3*lsb), code length
   localparam logic [BYTE_W-1:0] LVL0_MAX = 8'd3;
   localparam logic [BYTE_W-1:0] LVL1_MAX = 8'd7;
   localparam logic [BYTE_W-1:0] LVL2_MAX = 8'd15;
   localparam logic [BYTE_W-1:0] LVL3_MAX = 8'd31;

   typedef struct packed {
      logic [BPP_W-1:0] bpp;
      logic [LEN_W-1:0] code_len;
   } lpe_level_type;

   // Pop request from the code generator to the bit buffer
   typedef struct packed {
      logic             pop;
      logic [BPP_W-1:0] bpp;
   } lpe_pop_req_type;

   // Status of the bit buffer for the current request
   typedef struct packed {
      logic              refused;
      logic              padded;
      logic [BITS_W-1:0] bits;
   } lpe_buf_status_type;

   function automatic lpe_level_type lookup_level(input logic [BYTE_W-1:0] colors);
      lpe_level_type lvl;
      if (colors <= LVL0_MAX) begin
         lvl.bpp = 3'd6; lvl.code_len = 4'd8;
      end else if (colors <= LVL1_MAX) begin
         lvl.bpp = 3'd3; lvl.code_len = 4'd6;
      end else if (colors <= LVL2_MAX) begin
         lvl.bpp = 3'd3; lvl.code_len = 4'd7;
      end else if (colors <= LVL3_MAX) begin
         lvl.bpp = 3'd3; lvl.code_len = 4'd8;
      end else begin
         lvl.bpp = 3'd0; lvl.code_len = 4'd8;
      end
      return lvl;
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/lpe_bit_buffer.sv
// MSB-first payload bit buffer: byte pushes, variable-width pops with zero padding.
`timescale 1ns / 1ps
`default_nettype none

module lpe_bit_buffer
   import lpe_pkg::*;
#(
   parameter int unsigned BUFFER_BITS = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 push_en,
   input  wire logic [BYTE_W-1:0]                    push_byte,
   input  wire lpe_pop_req_type                      pop_req,
   output lpe_buf_status_type                        status,
   output logic [$clog2(BUFFER_BITS+1)-1:0]          fill_next
);

   localparam int unsigned FW = $clog2(BUFFER_BITS + 1);
   localparam int unsigned SW = FW + 1;

   logic [BUFFER_BITS-1:0] store_ff, store_in;
   logic [FW-1:0]          fill_ff, fill_in;

   logic [SW-1:0]          push_sum;
   logic                   push_fits;
   logic [FW-1:0]          push_fill;
   logic [BUFFER_BITS-1:0] push_store;

   logic [FW-1:0]          pop_bpp;
   logic                   pop_short;
   logic [FW-1:0]          pad_shift;
   logic [FW-1:0]          pop_fill;
   logic [BITS_W-1:0]      pop_mask;
   logic [BITS_W-1:0]      short_bits;
   logic [BITS_W-1:0]      long_bits;
   logic [BUFFER_BITS-1:0] keep_mask;

   // push path: room check and shifted-in byte
   assign push_sum   = {1'b0, fill_ff} + SW'(BYTE_W);
   assign push_fits  = push_sum <= SW'(BUFFER_BITS);
   assign push_fill  = push_sum[FW-1:0];
   assign push_store = ((store_ff << BYTE_W) | BUFFER_BITS'(push_byte))
                       & ~({BUFFER_BITS{1'b1}} << push_fill);

   // pop path: short buffer pads low bits, otherwise take the top bpp bits
   assign pop_bpp    = FW'(pop_req.bpp);
   assign pop_short  = fill_ff < pop_bpp;
   assign pad_shift  = pop_bpp - fill_ff;
   assign pop_fill   = fill_ff - pop_bpp;
   assign pop_mask   = ~({BITS_W{1'b1}} << pop_req.bpp);
   assign short_bits = BITS_W'(store_ff[BITS_W-1:0] << pad_shift);
   assign long_bits  = BITS_W'(store_ff >> pop_fill) & pop_mask;
   assign keep_mask  = ~({BUFFER_BITS{1'b1}} << pop_fill);

   // next state and status
   always_comb begin
      store_in = store_ff;
      fill_in  = fill_ff;
      status   = '0;
      if (push_en) begin
         if (push_fits) begin
            store_in = push_store;
            fill_in  = push_fill;
         end else begin
            status.refused = 1'b1;
         end
      end else if (pop_req.pop) begin
         if (pop_short) begin
            status.bits   = short_bits;
            status.padded = 1'b1;
            store_in      = '0;
            fill_in       = '0;
         end else begin
            status.bits = long_bits;
            store_in    = store_ff & keep_mask;
            fill_in     = pop_fill;
         end
      end
   end

   assign fill_next = fill_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         store_ff <= '0;
         fill_ff  <= '0;
      end else begin
         store_ff <= store_in;
         fill_ff  <= fill_in;
      end
   end

   // fill never exceeds the buffer size
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(BUFFER_BITS))
      else $error("bit buffer fill above capacity");

   // a refused byte leaves the buffer alone
   a_refuse_hold: assert property (@(posedge clock) disable iff (reset)
      (push_en && !push_fits) |=> ($stable(fill_ff) && $stable(store_ff)))
      else $error("refused byte changed the bit buffer");

   // padding always drains the buffer
   a_pad_empty: assert property (@(posedge clock) disable iff (reset)
      (!push_en && pop_req.pop && pop_short) |=> (fill_ff == '0 && store_ff == '0))
      else $error("padded pop left bits in the buffer");

endmodule

`default_nettype wire

// File: rtl/core/lpe_code_gen.sv
// Pixel code generation: level lookup, header and transparent codes, payload-offset code.
`timescale 1ns / 1ps
`default_nettype none

module lpe_code_gen
   import lpe_pkg::*;
(
   input  wire logic                take,
   input  wire logic                mode,
   input  wire logic [BYTE_W-1:0]   pixel_index,
   input  wire logic [BYTE_W-1:0]   num_colors,
   input  wire logic                first_pending,
   input  wire logic [BITS_W-1:0]   bits,
   output lpe_pop_req_type          pop_req,
   output logic [CODE_W-1:0]        pixel_code
);

   lpe_level_type           level;
   logic                    transparent;
   logic [CODE_W-1:0]       top_code;
   logic [BYTE_W+BITS_W-1:0] product;

   assign level       = lookup_level(num_colors);
   assign transparent = pixel_index == num_colors;

   // 2^m - 1, with m = 8 giving 255
   assign top_code = CODE_W'((9'd1 << level.code_len) - 9'd1);

   assign product = {{BITS_W{1'b0}}, num_colors} * {{BYTE_W{1'b0}}, bits};

   // only a regular pixel consumes payload bits
   always_comb begin
      pop_req.pop = take && (mode == MODE_PIXEL) && !first_pending && !transparent;
      pop_req.bpp = level.bpp;
   end

   // code select
   always_comb begin
      if (mode != MODE_PIXEL) begin
         pixel_code = '0;
      end else if (first_pending) begin
         pixel_code = top_code - CODE_W'(1);
      end else if (transparent) begin
         pixel_code = top_code;
      end else begin
         pixel_code = product[CODE_W-1:0] + pixel_index;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/lsb_payload_pixel_embedder_core.sv
// Top level of the LSB payload pixel embedder: request handshake, config and result register.
//
// Takes one request per clock cycle while req_stall is low: a payload byte push or a palette pixel
// index. All work is done in one pass of logic between the bit buffer state and the result
// register, so a result appears in the cycle after its request is accepted.
// The result register holds a finished result while rsp_stall is high; req_stall is raised only
// while that held result is stalled. num_colors is written through csr_write_en/csr_write_data
// and must only change while the block is idle. BUFFER_BITS sets the payload buffer depth
// (14 to 32); a byte is refused when it would overflow the buffer.
`timescale 1ns / 1ps
`default_nettype none

module lsb_payload_pixel_embedder_core
   import lpe_pkg::*;
#(
   parameter int unsigned BUFFER_BITS = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   // configuration
   input  wire logic                csr_write_en,
   input  wire logic [BYTE_W-1:0]   csr_write_data,
   // requests
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic                req_mode,
   input  wire logic [BYTE_W-1:0]   req_payload_byte,
   input  wire logic [BYTE_W-1:0]   req_pixel_index,
   // results
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [CODE_W-1:0]        rsp_pixel_code,
   output logic                     rsp_byte_refused,
   output logic                     rsp_bits_padded,
   output logic [HELD_W-1:0]        rsp_bits_held
);

   localparam int unsigned FW = $clog2(BUFFER_BITS + 1);

   logic [BYTE_W-1:0]  num_colors_ff, num_colors_in;
   logic               first_pending_ff, first_pending_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [CODE_W-1:0]  rsp_pixel_code_ff;
   logic               rsp_byte_refused_ff;
   logic               rsp_bits_padded_ff;
   logic [HELD_W-1:0]  rsp_bits_held_ff;

   logic               accept;
   lpe_pop_req_type    pop_req;
   lpe_buf_status_type buf_status;
   logic [FW-1:0]      fill_next;
   logic [CODE_W-1:0]  pixel_code;
   logic [BITS_W-1:0]  fill_wide;

   // handshake
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   lpe_code_gen u_code_gen (
      .take          (accept),
      .mode          (req_mode),
      .pixel_index   (req_pixel_index),
      .num_colors    (num_colors_ff),
      .first_pending (first_pending_ff),
      .bits          (buf_status.bits),
      .pop_req       (pop_req),
      .pixel_code    (pixel_code)
   );

   lpe_bit_buffer #(
      .BUFFER_BITS (BUFFER_BITS)
   ) u_bit_buffer (
      .clock     (clock),
      .reset     (reset),
      .push_en   (accept && (req_mode == MODE_BYTE)),
      .push_byte (req_payload_byte),
      .pop_req   (pop_req),
      .status    (buf_status),
      .fill_next (fill_next)
   );

   // bits_held wraps to its 5 bits
   assign fill_wide = BITS_W'(fill_next);

   // control next state
   always_comb begin
      num_colors_in    = csr_write_en ? csr_write_data : num_colors_ff;
      first_pending_in = (accept && (req_mode == MODE_PIXEL)) ? 1'b0 : first_pending_ff;
      rsp_valid_in     = accept || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_colors_ff    <= NUM_COLORS_RESET;
         first_pending_ff <= 1'b1;
         rsp_valid_ff     <= 1'b0;
      end else begin
         num_colors_ff    <= num_colors_in;
         first_pending_ff <= first_pending_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_pixel_code_ff   <= pixel_code;
         rsp_byte_refused_ff <= buf_status.refused;
         rsp_bits_padded_ff  <= buf_status.padded;
         rsp_bits_held_ff    <= fill_wide[HELD_W-1:0];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pixel_code   = rsp_pixel_code_ff;
   assign rsp_byte_refused = rsp_byte_refused_ff;
   assign rsp_bits_padded  = rsp_bits_padded_ff;
   assign rsp_bits_held    = rsp_bits_held_ff;

   // header is used up by the first accepted pixel
   a_header_once: assert property (@(posedge clock) disable iff (reset)
      (accept && req_mode == MODE_PIXEL) |=> !first_pending_ff)
      else $error("header pending after a pixel request");

   // a padded result reports an empty buffer
   a_pad_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_bits_padded_ff) |-> (rsp_bits_held_ff == '0))
      else $error("padded result with bits still held");

   // byte and pixel flags never show together
   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_byte_refused_ff && rsp_bits_padded_ff))
      else $error("refused and padded flags both set");

endmodule

`default_nettype wire
